FILE: hw/rtl/rtsd_pkg.sv
package rtsd_pkg;

	localparam int POS_WIDTH_DEF   = 32;
	localparam int VEL_WIDTH_DEF   = 24;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int ID_BITS         = 32;
	localparam int RANGE_BITS      = 34;
	localparam int SPEED_BITS      = 26;
	localparam int CORDIC_STEPS    = 32;
	localparam int CORDIC_BITS     = 64;
	localparam int TURN_BITS       = 32;

	// arctangent of 2^-i in 2^-32 turn units
	function automatic logic [TURN_BITS-1:0] atan_turn(input logic [4:0] i);
		logic [TURN_BITS-1:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/rtsd_sqrt.sv
module rtsd_sqrt #(
	parameter int W = 66
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   rad,
	output logic           done,
	output logic [W/2:0]   root
);

	localparam int STEPS = W / 2;
	localparam int CW    = $clog2(STEPS + 1);

	logic [W-1:0] op_q, res_q, one_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, fin_q, done_q;
	logic [W:0] trial;
	logic ge;

	assign trial = {1'b0, res_q} + {1'b0, one_q};
	assign ge    = {1'b0, op_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= rad;
			res_q <= '0;
			one_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (ge) begin
				op_q  <= op_q - trial[W-1:0];
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
		// round to nearest: up when the remainder exceeds the root
		if (fin_q)
			root <= res_q[W/2:0] + ((op_q > res_q) ? (W/2+1)'(1) : (W/2+1)'(0));
	end

	assign done = done_q;

endmodule

FILE: hw/rtl/rtsd_div.sv
module rtsd_div #(
	parameter int NW = 60,
	parameter int QW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int CW = $clog2(QW + 1);

	logic [NW-1:0] rem_q, dsh_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/rtsd_cordic.sv
module rtsd_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [rtsd_pkg::CORDIC_BITS-1:0] x_in,
	input  logic signed [rtsd_pkg::CORDIC_BITS-1:0] y_in,
	output logic                                   done,
	output logic [rtsd_pkg::TURN_BITS-1:0]          angle
);

	localparam int XW = rtsd_pkg::CORDIC_BITS;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;
	localparam logic [XW-1:0] LIM_FINE   = XW'(1) << 59;
	localparam logic [XW-1:0] LIM_COARSE = XW'(1) << 51;

	logic [1:0] state_q;
	logic [4:0] i_q;
	logic done_q;
	logic signed [XW-1:0] x_q, y_q, xs, ys;
	logic [rtsd_pkg::TURN_BITS-1:0] z_q;
	logic [XW-1:0] ymag, mx;

	assign ymag = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
	assign mx   = (XW'(x_q) > ymag) ? XW'(x_q) : ymag;
	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (x_in == '0 && y_in == '0)
							done_q <= 1'b1;
						else
							state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (mx >= LIM_FINE) begin
						state_q <= ST_ITER;
						i_q     <= '0;
					end
				end
				ST_ITER: begin
					if (i_q == 5'(rtsd_pkg::CORDIC_STEPS - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
					i_q <= i_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					// turn by half a turn into the right half plane
					if (x_in < 0) begin
						x_q <= -x_in;
						y_q <= -y_in;
						z_q <= 32'h8000_0000;
					end else begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end
				end
			end
			ST_NORM: begin
				if (mx < LIM_COARSE) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (mx < LIM_FINE) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			ST_ITER: begin
				if (!y_q[XW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + rtsd_pkg::atan_turn(i_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - rtsd_pkg::atan_turn(i_q);
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

FILE: hw/rtl/radar_target_to_spherical_doppler.sv
// Load items (tuser opcode 0) give no result. A target goes through multiply, check,
// range and horizontal square roots, azimuth and elevation CORDIC, divide and output
// in that order; the azimuth pass ends at once straight above or below, and with no
// detection the check goes straight to output.
// One item at a time; s_tready is high only while the sequencer is idle.
// Reset clears the own-radar state to zero (radar not valid) and drops any pending beat.
module radar_target_to_spherical_doppler #(
	parameter int POS_WIDTH   = rtsd_pkg::POS_WIDTH_DEF,
	parameter int VEL_WIDTH   = rtsd_pkg::VEL_WIDTH_DEF,
	parameter int ANGLE_WIDTH = rtsd_pkg::ANGLE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, target tag, zero fill
	input  logic [((3*POS_WIDTH+3*VEL_WIDTH+ANGLE_WIDTH+rtsd_pkg::ID_BITS+7)/8)*8-1:0] s_tdata,
	// opcode, item_valid
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// echo_id, slant_range, azimuth, elevation, closing_speed, zero fill
	output logic [((rtsd_pkg::ID_BITS+rtsd_pkg::RANGE_BITS+2*ANGLE_WIDTH
		+rtsd_pkg::SPEED_BITS+7)/8)*8-1:0] m_tdata,
	// detected
	output logic [0:0] m_tuser
);

	localparam int P   = POS_WIDTH;
	localparam int V   = VEL_WIDTH;
	localparam int A   = ANGLE_WIDTH;
	localparam int IDB = rtsd_pkg::ID_BITS;
	localparam int RB  = rtsd_pkg::RANGE_BITS;
	localparam int SB  = rtsd_pkg::SPEED_BITS;
	localparam int XW  = rtsd_pkg::CORDIC_BITS;
	localparam int TB  = rtsd_pkg::TURN_BITS;
	localparam int OWD = ((IDB + RB + 2*A + SB + 7) / 8) * 8;
	localparam int OFF_PY = P;
	localparam int OFF_PZ = 2*P;
	localparam int OFF_VX = 3*P;
	localparam int OFF_VY = 3*P + V;
	localparam int OFF_VZ = 3*P + 2*V;
	localparam int OFF_HD = 3*P + 3*V;
	localparam int OFF_ID = 3*P + 3*V + A;

	localparam int SW  = 2*P + 2;
	localparam int RW  = SW/2 + 1;
	localparam int MW  = (P + 1 > V + 1) ? P + 1 : V + 1;
	localparam int PRW = MW + P + 1;
	localparam int ACW = (SW + 1 > V + P + 3) ? SW + 1 : V + P + 3;
	localparam int QW  = V + 2;
	localparam int DVW = P + V + 4;
	localparam int EW  = (RW > RB) ? RW : RB;
	localparam int EQ  = (QW > SB) ? QW : SB;
	localparam logic [EW-1:0] RANGE_MAX = EW'({RB{1'b1}});
	localparam logic [EQ-1:0] SPD_POS   = EQ'({(SB-1){1'b1}});
	localparam logic [EQ-1:0] SPD_NEG   = EQ'(1) << (SB - 1);
	localparam logic [TB-1:0] ROUND_HALF = TB'(1) << (TB - 1 - A);

	localparam logic OP_LOAD = 1'b0;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_CHK   = 4'd2;
	localparam logic [3:0] ST_SQR_R = 4'd3;
	localparam logic [3:0] ST_SQR_H = 4'd4;
	localparam logic [3:0] ST_COR_A = 4'd5;
	localparam logic [3:0] ST_COR_E = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0] state_q;
	logic [2:0] k_q;

	logic [P-1:0] own_x_q, own_y_q, own_z_q;
	logic [V-1:0] own_vx_q, own_vy_q, own_vz_q;
	logic [A-1:0] own_heading_q;
	logic own_valid_q;

	logic signed [P:0] dx_q, dy_q, dz_q;
	logic signed [V:0] vx_q, vy_q, vz_q;
	logic [IDB-1:0] id_q;
	logic item_valid_q, det_q;

	logic signed [MW-1:0] opa, opb;
	logic signed [PRW-1:0] mul_p, prod_s1;
	logic signed [ACW-1:0] acc_q, acc_sum;
	logic [SW-1:0] hs_q, s_q;
	logic [RW-1:0] r_q, h_q;
	logic [TB-1:0] az_q, el_q;
	logic [QW-1:0] q_q;

	logic accept, load_out, out_v_q;
	logic [IDB-1:0] o_id_q;
	logic o_det_q;
	logic [RB-1:0] o_rng_q;
	logic [A-1:0] o_az_q, o_el_q;
	logic [SB-1:0] o_spd_q;

	logic sq_start, sq_done, co_start, co_done, dv_start, dv_done;
	logic [SW-1:0] sq_rad;
	logic [RW-1:0] sq_root;
	logic signed [XW-1:0] co_x, co_y;
	logic [TB-1:0] co_angle;
	logic [ACW-1:0] dot_mag;
	logic [DVW-1:0] dv_num, dv_den;
	logic [QW-1:0] dv_quo;

	logic [P-1:0] in_px, in_py, in_pz;
	logic [V-1:0] in_vx, in_vy, in_vz;

	logic [EW-1:0] r_ext;
	logic [EQ-1:0] q_ext;
	logic [TB-1:0] az_rnd, el_rnd;
	logic [RB-1:0] rng_res;
	logic [SB-1:0] spd_res;

	assign in_px = s_tdata[P-1:0];
	assign in_py = s_tdata[OFF_PY +: P];
	assign in_pz = s_tdata[OFF_PZ +: P];
	assign in_vx = s_tdata[OFF_VX +: V];
	assign in_vy = s_tdata[OFF_VY +: V];
	assign in_vz = s_tdata[OFF_VZ +: V];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == ST_OUT) && (!out_v_q || m_tready);

	// one shared multiplier, squares first, then the dot product
	always_comb begin
		unique case (k_q)
			3'd0: begin opa = MW'(dx_q); opb = MW'(dx_q); end
			3'd1: begin opa = MW'(dy_q); opb = MW'(dy_q); end
			3'd2: begin opa = MW'(dz_q); opb = MW'(dz_q); end
			3'd3: begin opa = MW'(vx_q); opb = MW'(dx_q); end
			3'd4: begin opa = MW'(vy_q); opb = MW'(dy_q); end
			default: begin opa = MW'(vz_q); opb = MW'(dz_q); end
		endcase
		mul_p = opa * opb;
	end

	assign acc_sum = acc_q + ACW'(prod_s1);

	assign sq_start = ((state_q == ST_CHK) && own_valid_q && item_valid_q && (s_q != '0))
		|| ((state_q == ST_SQR_R) && sq_done);
	assign sq_rad   = (state_q == ST_CHK) ? s_q : hs_q;

	assign co_start = ((state_q == ST_SQR_H) && sq_done) || ((state_q == ST_COR_A) && co_done);
	assign co_x     = (state_q == ST_SQR_H) ? XW'(dx_q) : XW'(signed'({1'b0, h_q}));
	assign co_y     = (state_q == ST_SQR_H) ? XW'(dy_q) : XW'(dz_q);

	assign dv_start = (state_q == ST_COR_E) && co_done;
	assign dot_mag  = acc_q[ACW-1] ? ACW'(-acc_q) : ACW'(acc_q);
	assign dv_num   = (DVW'(dot_mag) << 1) + DVW'(r_q);
	assign dv_den   = DVW'(r_q) << 1;

	rtsd_sqrt #(.W(SW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	rtsd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (co_start),
		.x_in   (co_x),
		.y_in   (co_y),
		.done   (co_done),
		.angle  (co_angle)
	);

	rtsd_div #(.NW(DVW), .QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	// result formatting
	always_comb begin
		r_ext   = EW'(r_q);
		rng_res = (r_ext > RANGE_MAX) ? RB'(RANGE_MAX) : r_ext[RB-1:0];
		az_rnd  = az_q + ROUND_HALF;
		el_rnd  = el_q + ROUND_HALF;
		q_ext   = EQ'(q_q);
		if (acc_q[ACW-1])
			spd_res = SB'(0) - ((q_ext > SPD_NEG) ? SB'(SPD_NEG) : q_ext[SB-1:0]);
		else
			spd_res = (q_ext > SPD_POS) ? SB'(SPD_POS) : q_ext[SB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= '0;
			own_x_q       <= '0;
			own_y_q       <= '0;
			own_z_q       <= '0;
			own_vx_q      <= '0;
			own_vy_q      <= '0;
			own_vz_q      <= '0;
			own_heading_q <= '0;
			own_valid_q   <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if (load_out)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser[0] == OP_LOAD) begin
							own_x_q       <= in_px;
							own_y_q       <= in_py;
							own_z_q       <= in_pz;
							own_vx_q      <= in_vx;
							own_vy_q      <= in_vy;
							own_vz_q      <= in_vz;
							own_heading_q <= s_tdata[OFF_HD +: A];
							own_valid_q   <= s_tuser[1];
						end else begin
							state_q <= ST_MUL;
							k_q     <= '0;
						end
					end
				end
				ST_MUL: begin
					if (k_q == 3'd6)
						state_q <= ST_CHK;
					k_q <= k_q + 1'b1;
				end
				ST_CHK:   state_q <= sq_start ? ST_SQR_R : ST_OUT;
				ST_SQR_R: if (sq_done) state_q <= ST_SQR_H;
				ST_SQR_H: if (sq_done) state_q <= ST_COR_A;
				ST_COR_A: if (co_done) state_q <= ST_COR_E;
				ST_COR_E: if (co_done) state_q <= ST_DIV;
				ST_DIV:   if (dv_done) state_q <= ST_OUT;
				ST_OUT:   if (load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q <= {in_px[P-1], in_px} - {own_x_q[P-1], own_x_q};
			dy_q <= {in_py[P-1], in_py} - {own_y_q[P-1], own_y_q};
			dz_q <= {in_pz[P-1], in_pz} - {own_z_q[P-1], own_z_q};
			vx_q <= {in_vx[V-1], in_vx} - {own_vx_q[V-1], own_vx_q};
			vy_q <= {in_vy[V-1], in_vy} - {own_vy_q[V-1], own_vy_q};
			vz_q <= {in_vz[V-1], in_vz} - {own_vz_q[V-1], own_vz_q};
			id_q <= s_tdata[OFF_ID +: IDB];
			item_valid_q <= s_tuser[1];
		end

		if (state_q == ST_MUL) begin
			prod_s1 <= mul_p;
			unique case (k_q)
				3'd1, 3'd4: acc_q <= ACW'(prod_s1);
				3'd2: begin
					acc_q <= acc_sum;
					hs_q  <= acc_sum[SW-1:0];
				end
				3'd3: s_q <= acc_sum[SW-1:0];
				3'd5, 3'd6: acc_q <= acc_sum;
				default: ;
			endcase
		end

		if (state_q == ST_CHK)
			det_q <= sq_start;
		if (state_q == ST_SQR_R && sq_done)
			r_q <= sq_root;
		if (state_q == ST_SQR_H && sq_done)
			h_q <= sq_root;
		if (state_q == ST_COR_A && co_done)
			az_q <= co_angle;
		if (state_q == ST_COR_E && co_done)
			el_q <= co_angle;
		if (state_q == ST_DIV && dv_done)
			q_q <= dv_quo;

		if (load_out) begin
			o_id_q  <= id_q;
			o_det_q <= det_q;
			if (det_q) begin
				o_rng_q <= rng_res;
				o_az_q  <= az_rnd[TB-1 -: A] - own_heading_q;
				o_el_q  <= el_rnd[TB-1 -: A];
				o_spd_q <= spd_res;
			end else begin
				o_rng_q <= '0;
				o_az_q  <= '0;
				o_el_q  <= '0;
				o_spd_q <= '0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OWD'({o_spd_q, o_el_q, o_az_q, o_rng_q, o_id_q});
	assign m_tuser  = o_det_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int POS_W = rtsd_pkg::POS_WIDTH_DEF;
	localparam int VEL_W = rtsd_pkg::VEL_WIDTH_DEF;
	localparam int ANG_W = rtsd_pkg::ANGLE_WIDTH_DEF;
	localparam int ID_BITS    = rtsd_pkg::ID_BITS;
	localparam int RANGE_BITS = rtsd_pkg::RANGE_BITS;
	localparam int SPEED_BITS = rtsd_pkg::SPEED_BITS;
	localparam int S_BITS = ((3*POS_W+3*VEL_W+ANG_W+ID_BITS+7)/8)*8;
	localparam int M_BITS = ((ID_BITS+RANGE_BITS+2*ANG_W+SPEED_BITS+7)/8)*8;
	localparam int IDLE_LIMIT = 20000;

	typedef enum logic {OP_LOAD = 1'b0, OP_TARGET = 1'b1} op_e;

	typedef struct {
		op_e                     op;
		logic                    ok;
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [VEL_W-1:0] vx, vy, vz;
		logic signed [ANG_W-1:0] hdg;
		logic [ID_BITS-1:0]      id;
		bit                      drain;
	} track_t;

	typedef struct {
		logic [ID_BITS-1:0]        id;
		logic                      det;
		logic [RANGE_BITS-1:0]     rng;
		logic [ANG_W-1:0]          az;
		logic [ANG_W-1:0]          el;
		logic [SPEED_BITS-1:0]     spd;
	} detection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [S_BITS-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic [M_BITS-1:0] m_tdata;
	logic [0:0] m_tuser;

	track_t     pending[$];
	detection_t detections_due[$];
	int         errors = 0;
	int         idle_cycles = 0;

	// own-radar state as the predictor sees it
	logic signed [POS_W-1:0] own_px, own_py, own_pz;
	logic signed [VEL_W-1:0] own_vx, own_vy, own_vz;
	logic signed [ANG_W-1:0] own_hdg;
	logic                    own_ok;

	localparam logic [31:0] ATAN_TURN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

	always #2 clk = ~clk;

	radar_target_to_spherical_doppler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic logic [63:0] root_nearest(logic [127:0] s);
		logic [63:0] r, c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s)
				r = c;
		end
		if (s > {64'd0, r} * ({64'd0, r} + 128'd1))
			r = r + 64'd1;
		return r;
	endfunction

	function automatic logic [ANG_W-1:0] bearing_code(longint x, longint y);
		logic [31:0] z;
		longint xs, ys, ay;
		longint unsigned m;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		ay = (y < 0) ? -y : y;
		m = (x > ay) ? x : ay;
		while (m < (64'd1 << 59)) begin
			x = x * 2;
			y = y * 2;
			m = m << 1;
		end
		for (int i = 0; i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURN[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURN[i];
			end
		end
		z = z + (32'd1 << (31 - ANG_W));
		return z[31 -: ANG_W];
	endfunction

	// returns 1 when the beat yields a detection record
	function automatic bit sight_target(input track_t t, output detection_t d);
		longint dx, dy, dz, mx, my, mz, dot, mag_dot;
		logic [127:0] hs, ss;
		longint unsigned r, h, q;
		d = '{default: '0};
		if (t.op == OP_LOAD) begin
			own_px = t.px; own_py = t.py; own_pz = t.pz;
			own_vx = t.vx; own_vy = t.vy; own_vz = t.vz;
			own_hdg = t.hdg; own_ok = t.ok;
			return 0;
		end
		d.id = t.id;
		dx = longint'(t.px) - longint'(own_px);
		dy = longint'(t.py) - longint'(own_py);
		dz = longint'(t.pz) - longint'(own_pz);
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		mz = (dz < 0) ? -dz : dz;
		hs = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
		ss = hs + 128'(mz) * 128'(mz);
		if (!own_ok || !t.ok || ss == 0)
			return 1;
		r = root_nearest(ss);
		h = root_nearest(hs);
		d.det = 1'b1;
		d.rng = (r > (64'd1 << RANGE_BITS) - 64'd1) ? '1 : r[RANGE_BITS-1:0];
		d.az = bearing_code(dx, dy) - own_hdg;
		d.el = bearing_code(longint'(h), dz);
		dot = (longint'(t.vx) - longint'(own_vx)) * dx
			+ (longint'(t.vy) - longint'(own_vy)) * dy
			+ (longint'(t.vz) - longint'(own_vz)) * dz;
		mag_dot = (dot < 0) ? -dot : dot;
		q = (2 * longint'(mag_dot) + r) / (2 * r);
		if (dot < 0) begin
			if (q > (64'd1 << (SPEED_BITS - 1)))
				q = 64'd1 << (SPEED_BITS - 1);
			d.spd = SPEED_BITS'(-q);
		end else begin
			if (q > (64'd1 << (SPEED_BITS - 1)) - 1)
				q = (64'd1 << (SPEED_BITS - 1)) - 1;
			d.spd = q[SPEED_BITS-1:0];
		end
		return 1;
	endfunction

	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sender
	int  send_gap;
	bit  send_burst;
	always @(posedge clk or negedge arst_n) begin
		track_t nt;
		detection_t d;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			send_gap = 0;
			send_burst = 0;
			own_px = '0; own_py = '0; own_pz = '0;
			own_vx = '0; own_vy = '0; own_vz = '0;
			own_hdg = '0; own_ok = 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				nt.op = op_e'(s_tuser[0]);
				nt.ok = s_tuser[1];
				{nt.id, nt.hdg, nt.vz, nt.vy, nt.vx, nt.pz, nt.py, nt.px} = s_tdata;
				if (sight_target(nt, d))
					detections_due.push_back(d);
				if ($urandom_range(0, 49) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : gap_length();
			end
			if (send_gap > 0 || pending.size() == 0
				|| (pending[0].drain && detections_due.size() != 0)) begin
				if (send_gap > 0)
					send_gap--;
				s_tvalid <= 1'b0;
			end else begin
				nt = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= {nt.ok, nt.op};
				s_tdata  <= {nt.id, nt.hdg, nt.vz, nt.vy, nt.vx, nt.pz, nt.py, nt.px};
			end
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		detection_t w, g;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				{g.spd, g.el, g.az, g.rng, g.id} = m_tdata[ID_BITS+RANGE_BITS+2*ANG_W+SPEED_BITS-1:0];
				g.det = m_tuser[0];
				if (detections_due.size() == 0) begin
					$display("%0t: unexpected beat, actual id %0h", $time, g.id);
					errors++;
				end else begin
					w = detections_due.pop_front();
					check_field("echo_id", 64'(w.id), 64'(g.id));
					check_field("detected", 64'(w.det), 64'(g.det));
					check_field("slant_range", 64'(w.rng), 64'(g.rng));
					check_field("azimuth", 64'(w.az), 64'(g.az));
					check_field("elevation", 64'(w.el), 64'(g.el));
					check_field("closing_speed", 64'(w.spd), 64'(g.spd));
				end
				recv_gap = gap_length();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic track_t make_item(op_e op, logic ok, longint x, longint y, longint z,
		longint vx, longint vy, longint vz, longint hdg);
		track_t t;
		t.op = op; t.ok = ok;
		t.px = POS_W'(x); t.py = POS_W'(y); t.pz = POS_W'(z);
		t.vx = VEL_W'(vx); t.vy = VEL_W'(vy); t.vz = VEL_W'(vz);
		t.hdg = ANG_W'(hdg);
		t.id = $urandom;
		t.drain = 0;
		return t;
	endfunction

	function automatic logic [POS_W-1:0] near_pos(logic [POS_W-1:0] base);
		logic signed [POS_W-1:0] off;
		off = POS_W'($urandom);
		off = off >>> $urandom_range(0, 31);
		return ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : base + off;
	endfunction

	function automatic logic [VEL_W-1:0] some_vel();
		logic signed [VEL_W-1:0] v;
		v = VEL_W'($urandom);
		return v >>> $urandom_range(0, VEL_W - 1);
	endfunction

	initial begin
		track_t t;
		logic [POS_W-1:0] bx, by, bz;
		longint pmax, pmin, vmax, vmin;
		pmax = (longint'(1) << (POS_W-1)) - 1; pmin = -(longint'(1) << (POS_W-1));
		vmax = (longint'(1) << (VEL_W-1)) - 1; vmin = -(longint'(1) << (VEL_W-1));

		// radar not yet valid after reset
		pending.push_back(make_item(OP_TARGET, 1, 100, 200, 300, 5, 5, 5, 0));
		pending.push_back(make_item(OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(make_item(OP_TARGET, 1, 0, 0, 0, 7, 7, 7, 0));
		pending.push_back(make_item(OP_TARGET, 0, 1000, 0, 0, 1, 0, 0, 0));
		pending.push_back(make_item(OP_TARGET, 1, 1, 0, 0, 1, 0, 0, 0));
		pending.push_back(make_item(OP_TARGET, 1, -1, 0, 0, 1, 0, 0, 0));
		pending.push_back(make_item(OP_TARGET, 1, -5000, 0, 0, vmin, 0, 0, 0));
		pending.push_back(make_item(OP_TARGET, 1, 0, 0, 1, 0, 0, vmax, 0));
		pending.push_back(make_item(OP_TARGET, 1, 0, 0, -1, 0, 0, vmin, 0));
		pending.push_back(make_item(OP_TARGET, 1, 0, -3, 0, 0, 0, 0, 0));
		pending.push_back(make_item(OP_LOAD, 1, pmin, pmin, pmin, vmin, vmin, vmin, -32768));
		pending.push_back(make_item(OP_TARGET, 1, pmax, pmax, pmax, vmax, vmax, vmax, 0));
		pending.push_back(make_item(OP_TARGET, 1, pmax, pmin, pmin, vmax, vmin, vmax, 0));
		pending.push_back(make_item(OP_LOAD, 1, pmax, pmax, pmax, vmax, vmax, vmax, 32767));
		pending.push_back(make_item(OP_TARGET, 1, pmin, pmin, pmin, vmin, vmin, vmin, 0));
		pending.push_back(make_item(OP_TARGET, 1, pmin, pmax, pmax, vmin, vmin, vmin, 0));
		t = make_item(OP_LOAD, 0, 10, 20, 30, 1, 2, 3, 4096);
		t.drain = 1;
		pending.push_back(t);
		pending.push_back(make_item(OP_TARGET, 1, 500, 600, 700, 9, 9, 9, 0));
		pending.push_back(make_item(OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 16384));
		pending.push_back(make_item(OP_TARGET, 1, -7, -7, 0, 0, 0, 0, 0));
		t = make_item(OP_TARGET, 1, 0, 0, 0, 0, 0, 0, 0);
		t.id = '1;
		pending.push_back(t);

		bx = '0; by = '0; bz = '0;
		for (int n = 0; n < 1100; n++) begin
			if ($urandom_range(0, 99) < 12) begin
				t.op = OP_LOAD;
				t.ok = ($urandom_range(0, 9) != 0);
				bx = $urandom; by = $urandom; bz = $urandom;
				if ($urandom_range(0, 1)) begin
					bx = bx >>> $urandom_range(0, 31);
					by = by >>> $urandom_range(0, 31);
					bz = bz >>> $urandom_range(0, 31);
				end
				t.px = bx; t.py = by; t.pz = bz;
				t.hdg = ANG_W'($urandom);
			end else begin
				t.op = OP_TARGET;
				t.ok = ($urandom_range(0, 19) != 0);
				t.px = near_pos(bx); t.py = near_pos(by); t.pz = near_pos(bz);
				if ($urandom_range(0, 49) == 0) begin
					t.px = bx; t.py = by; t.pz = bz;
				end
				t.hdg = ANG_W'($urandom);
			end
			t.vx = some_vel(); t.vy = some_vel(); t.vz = some_vel();
			t.id = $urandom;
			t.drain = ($urandom_range(0, 199) == 0);
			pending.push_back(t);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending.size() != 0 || s_tvalid || detections_due.size() != 0);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
